[rtl/core/spn16_pkg.sv]
// spn16_pkg: S-box tables, bit transpose, round key selection and per-cell
// control for the 16-bit SPN cipher core. No dependencies.
`timescale 1ns / 1ps

package spn16_pkg;

    localparam int unsigned NUM_CELLS = 4;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'd14, 4'd3,  4'd4,  4'd8,  4'd1,  4'd12, 4'd10, 4'd15,
        4'd7,  4'd13, 4'd9,  4'd6,  4'd11, 4'd2,  4'd0,  4'd5
    };

    // Source bit of each output bit, 1-based, counted from the MSB.
    localparam logic [4:0] PERM_SRC [16] = '{
        5'd1, 5'd5, 5'd9,  5'd13, 5'd2, 5'd6, 5'd10, 5'd14,
        5'd3, 5'd7, 5'd11, 5'd15, 5'd4, 5'd8, 5'd12, 5'd16
    };

    // Work done by one cell: x ^ pre_key, optional transpose, S-box layer,
    // optional transpose, ^ post_key.
    typedef struct packed {
        logic [15:0] pre_key;
        logic [15:0] post_key;
        logic        pre_perm;
        logic        post_perm;
        logic        inv;
    } t_cell_ctl;

    function automatic logic [15:0] sub16(input logic [15:0] x, input logic inv);
        logic [15:0] y;
        y = '0;
        for (int n = 0; n < 4; n++) begin
            if (inv) begin
                y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
            end else begin
                y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
            end
        end
        return y;
    endfunction

    function automatic logic [15:0] transpose(input logic [15:0] x);
        logic [15:0] y;
        logic [4:0]  src;
        y = '0;
        for (int i = 0; i < 16; i++) begin
            src = 5'd16 - PERM_SRC[i];
            y[15 - i] = x[src[3:0]];
        end
        return y;
    endfunction

    // Round key r: 16 bits starting 4r bits below the key MSB.
    function automatic logic [15:0] round_key(input logic [31:0] key, input logic [2:0] r);
        logic [31:0] sh;
        sh = key >> (5'd16 - {r[2:0], 2'b00});
        return sh[15:0];
    endfunction

    function automatic t_cell_ctl cell_ctl(input logic [1:0] stage, input logic mode,
                                           input logic [31:0] key);
        t_cell_ctl c;
        c.inv = mode;
        if (mode == MODE_ENC) begin
            c.pre_key   = round_key(key, {1'b0, stage});
            c.pre_perm  = 1'b0;
            c.post_perm = (stage != 2'd3);
            c.post_key  = (stage == 2'd3) ? round_key(key, 3'd4) : 16'h0000;
        end else if (stage == 2'd0) begin
            c.pre_key   = round_key(key, 3'd4);
            c.pre_perm  = 1'b0;
            c.post_perm = 1'b0;
            c.post_key  = round_key(key, 3'd3);
        end else begin
            c.pre_key   = 16'h0000;
            c.pre_perm  = 1'b1;
            c.post_perm = 1'b0;
            c.post_key  = round_key(key, 3'd3 - {1'b0, stage});
        end
        return c;
    endfunction

endpackage

[rtl/core/spn16_cell.sv]
// spn16_cell: one round cell of the SPN pipeline, with its own valid flag.
// Depends on spn16_pkg.
`timescale 1ns / 1ps

module spn16_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [15:0]           i_data,
    input  spn16_pkg::t_cell_ctl  i_ctl,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_mode,
    output logic [15:0]           o_data
);

    logic        r_vld;
    logic        r_mode;
    logic [15:0] r_data;
    logic [15:0] n_data;
    logic [15:0] s0, s1, s2;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        s0     = i_data ^ i_ctl.pre_key;
        s1     = i_ctl.pre_perm ? spn16_pkg::transpose(s0) : s0;
        s2     = spn16_pkg::sub16(s1, i_ctl.inv);
        n_data = (i_ctl.post_perm ? spn16_pkg::transpose(s2) : s2) ^ i_ctl.post_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode <= i_mode;
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_mode  = r_mode;
    assign o_data  = r_data;

endmodule

[rtl/core/spn_block_cipher_16bit_core.sv]
// spn_block_cipher_16bit_core: top level of the 16-bit four-round SPN cipher.
// Depends on spn16_pkg and spn16_cell.
`timescale 1ns / 1ps

// Usage
// - Key port: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_data, the
//   32-bit master key. Write it only while no item is in flight.
// - Input channel: i_valid / o_ready with i_mode (0 encrypt, 1 decrypt) and
//   i_block_in. An item is taken when both are high.
// - Output channel: o_valid / i_ready with o_block_out, one result per item,
//   in input order.
// - Structure: a chain of four round cells; every cell holds one item and
//   hands it to the next cell each cycle that the next is ready. The last
//   cell is the output register.
// - Throughput: one item per cycle while the output is not stalled; each
//   cell does one round.
// - Stall: when i_ready is low the last cell holds its result; upstream
//   cells keep moving until they fill, so up to four items are held.
//   o_ready is a per-cell ready chain back to the input.
// - Reset (i_rst_n low, synchronous): all cells empty, key cleared to zero.
module spn_block_cipher_16bit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [15:0] i_block_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_block_out
);

    localparam int unsigned N = spn16_pkg::NUM_CELLS;

    logic [31:0] r_key;

    // Chain links: index k is the input side of cell k, index N the output.
    logic        vld  [N+1];
    logic        rdy  [N+1];
    logic        mode [N+1];
    logic [15:0] data [N+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 32'h0000_0000;
        end else if (i_cfg_valid) begin
            r_key <= i_cfg_data;
        end
    end

    assign vld[0]  = i_valid;
    assign mode[0] = i_mode;
    assign data[0] = i_block_in;
    assign o_ready = rdy[0];

    for (genvar k = 0; k < N; k++) begin : g_cell
        spn16_pkg::t_cell_ctl ctl;

        // Control follows the mode carried by the item entering this cell.
        assign ctl = spn16_pkg::cell_ctl(2'(k), mode[k], r_key);

        spn16_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_mode  (mode[k]),
            .i_data  (data[k]),
            .i_ctl   (ctl),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_mode  (mode[k+1]),
            .o_data  (data[k+1])
        );
    end

    assign rdy[N]      = i_ready;
    assign o_valid     = vld[N];
    assign o_block_out = data[N];

endmodule
